>>> hdl/lbs_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes and types for the linear blend skinning core
// no dependencies
package lbs_pkg;

    localparam int MAX_BONES_DEF      = 256;
    localparam int MAX_INFLUENCES_DEF = 4;
    localparam int WORDS_PER_BONE     = 12;
    localparam int ONE_Q16            = 65536;

    localparam logic [1:0] CMD_LOAD_WORD = 2'd0;
    localparam logic [1:0] CMD_SET_SLOT  = 2'd1;
    localparam logic [1:0] CMD_XFORM_POS = 2'd2;
    localparam logic [1:0] CMD_XFORM_DIR = 2'd3;

    // request to the shift-subtract unit
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } ds_req_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> hdl/linear_blend_skinning_vertex_core.sv
`timescale 1ns / 1ps
// linear blend skinning core: sequencer, bone matrix memory, influence slots
// depends on lbs_pkg, lbs_mul and lbs_divsqrt
//
// Matrix loads and slot sets are taken while idle and leave the input ready. A
// transform runs on one shared 33x33 multiplier: per active slot with a valid
// bone, each of the three rows steps through memory read, multiply and
// accumulate for each linear matrix word, then a read and an add of the
// translation word for a position, then the weight multiply and accumulate;
// each slot begins with a slot check. After the last slot check come the final
// saturation and the output. A direction then goes through squares, a square
// root and one division per component in the shift-subtract unit. The input is
// not ready during a transform; the result sits in an output register while the
// next item is taken.
module linear_blend_skinning_vertex_core
#(
    parameter int MAX_BONES      = lbs_pkg::MAX_BONES_DEF,
    parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // bone_index, word_index, matrix_value, slot_index, weight, vec_x, vec_y, vec_z
    input  logic [159:0]  s_tdata,
    // cmd
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_x, out_y, out_z
    output logic [95:0]   m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_data
);
    import lbs_pkg::*;

    localparam int MEM_DEPTH = MAX_BONES * WORDS_PER_BONE;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SW        = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
    localparam int CW        = $clog2(MAX_INFLUENCES + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SLOT    = 4'd1;
    localparam logic [3:0] ST_RD      = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_ACC     = 4'd4;
    localparam logic [3:0] ST_SATR    = 4'd5;
    localparam logic [3:0] ST_WACC    = 4'd6;
    localparam logic [3:0] ST_FIN     = 4'd7;
    localparam logic [3:0] ST_SQ      = 4'd8;
    localparam logic [3:0] ST_SQACC   = 4'd9;
    localparam logic [3:0] ST_SQRT_GO = 4'd10;
    localparam logic [3:0] ST_SQRT_W  = 4'd11;
    localparam logic [3:0] ST_DIV_GO  = 4'd12;
    localparam logic [3:0] ST_DIV_W   = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    // input fields
    logic [7:0]          in_bone;
    logic [3:0]          in_word;
    logic [31:0]         in_mval;
    logic [1:0]          in_slot;
    logic [16:0]         in_weight;
    assign in_bone   = s_tdata[7:0];
    assign in_word   = s_tdata[11:8];
    assign in_mval   = s_tdata[43:12];
    assign in_slot   = s_tdata[45:44];
    assign in_weight = s_tdata[62:46];

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    // state
    logic [3:0]         state_reg, state_next;
    logic [2:0]         active_reg;
    logic [7:0]         bone_reg [MAX_INFLUENCES];
    logic [16:0]        wt_reg [MAX_INFLUENCES];
    logic [CW-1:0]      slot_cnt_reg, slot_cnt_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [1:0]         r_reg, r_next;
    logic [1:0]         c_reg, c_next;
    logic               pos_reg, pos_next;
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic signed [63:0] row_reg, row_next;
    logic signed [63:0] acc_reg [3];
    logic signed [63:0] acc_next [3];
    logic signed [31:0] val_reg [3];
    logic signed [31:0] val_next [3];
    logic [63:0]        sq_reg, sq_next;
    logic [31:0]        len_reg, len_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [95:0]        m_tdata_reg, m_tdata_next;

    // matrix memory
    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    logic [SW-1:0] sidx;
    assign sidx = slot_cnt_reg[SW-1:0];

    assign wr_addr = AW'(int'(in_bone) * WORDS_PER_BONE + int'(in_word));
    assign wr_en   = in_xfer && (s_tuser == CMD_LOAD_WORD) && (int'(in_bone) < MAX_BONES)
                     && (int'(in_word) < WORDS_PER_BONE);
    assign rd_addr = AW'(int'(bone_reg[sidx]) * WORDS_PER_BONE + int'(r_reg) * 4
                     + int'(c_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_mval;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [63:0] prod64;
    logic signed [63:0] prod_q16;
    logic signed [31:0] row_sat;
    logic [1:0]         vi;

    lbs_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod64   = prod[63:0];
    assign prod_q16 = prod64 >>> 16;
    assign row_sat  = sat32(row_reg);
    assign vi       = r_reg;

    // magnitude of the component under work
    logic [32:0] mag;
    assign mag = val_reg[vi][31] ? 33'(-{val_reg[vi][31], val_reg[vi]})
                                 : {1'b0, val_reg[vi]};

    always_comb
    begin
        mul_a = {rd_data_reg[31], rd_data_reg};
        mul_b = {v_reg[c_reg][31], v_reg[c_reg]};
        if (state_reg == ST_SATR)
        begin
            mul_a = {row_sat[31], row_sat};
            mul_b = {16'b0, wt_reg[sidx]};
        end
        else if (state_reg == ST_SQ)
        begin
            mul_a = mag;
            mul_b = mag;
        end
    end

    // shift-subtract unit
    ds_req_t     ds_req;
    logic [63:0] ds_operand;
    logic        ds_done;
    logic [47:0] ds_result;

    assign ds_req.start     = (state_reg == ST_SQRT_GO) || (state_reg == ST_DIV_GO);
    assign ds_req.sqrt_mode = (state_reg == ST_SQRT_GO);
    assign ds_operand       = (state_reg == ST_SQRT_GO) ? sq_reg
                                                        : {mag[31:0], 32'b0};

    lbs_divsqrt u_divsqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ds_req),
        .operand (ds_operand),
        .divisor (len_reg),
        .done    (ds_done),
        .result  (ds_result)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        slot_cnt_next = slot_cnt_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        pos_next      = pos_reg;
        row_next      = row_reg;
        sq_next       = sq_reg;
        len_next      = len_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        for (int i = 0; i < 3; i++)
        begin
            v_next[i]   = v_reg[i];
            acc_next[i] = acc_reg[i];
            val_next[i] = val_reg[i];
        end

        // output transfer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_tuser == CMD_XFORM_POS || s_tuser == CMD_XFORM_DIR))
                begin
                    pos_next      = (s_tuser == CMD_XFORM_POS);
                    v_next[0]     = s_tdata[94:63];
                    v_next[1]     = s_tdata[126:95];
                    v_next[2]     = s_tdata[158:127];
                    n_next        = (int'(active_reg) > MAX_INFLUENCES)
                                    ? CW'(MAX_INFLUENCES) : CW'(active_reg);
                    slot_cnt_next = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                if (slot_cnt_reg == n_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (int'(bone_reg[sidx]) >= MAX_BONES)
                begin
                    slot_cnt_next = slot_cnt_reg + CW'(1);
                end
                else
                begin
                    r_next     = 2'd0;
                    c_next     = 2'd0;
                    row_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (c_reg == 2'd3)
                begin
                    row_next   = row_reg + 64'($signed(rd_data_reg));
                    state_next = ST_SATR;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                row_next = row_reg + prod_q16;
                c_next   = c_reg + 2'd1;
                if (c_reg == 2'd2)
                begin
                    state_next = pos_reg ? ST_RD : ST_SATR;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_SATR:
            begin
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                acc_next[r_reg] = acc_reg[r_reg] + prod_q16;
                if (r_reg == 2'd2)
                begin
                    slot_cnt_next = slot_cnt_reg + CW'(1);
                    state_next    = ST_SLOT;
                end
                else
                begin
                    r_next     = r_reg + 2'd1;
                    c_next     = 2'd0;
                    row_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    val_next[i] = sat32(acc_reg[i]);
                end
                r_next     = 2'd0;
                sq_next    = '0;
                state_next = pos_reg ? ST_OUT : ST_SQ;
            end
            ST_SQ:
            begin
                state_next = ST_SQACC;
            end
            ST_SQACC:
            begin
                sq_next = sq_reg + prod[63:0];
                r_next  = r_reg + 2'd1;
                state_next = (r_reg == 2'd2) ? ST_SQRT_GO : ST_SQ;
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_W;
            end
            ST_SQRT_W:
            begin
                if (ds_done)
                begin
                    len_next = ds_result[31:0];
                    r_next   = 2'd0;
                    if (ds_result[31:0] == 32'd0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            val_next[i] = '0;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                if (ds_done)
                begin
                    val_next[r_reg] = val_reg[r_reg][31] ? -ds_result[31:0] : ds_result[31:0];
                    r_next     = r_reg + 2'd1;
                    state_next = (r_reg == 2'd2) ? ST_OUT : ST_DIV_GO;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {val_reg[2], val_reg[1], val_reg[0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and influence slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= 3'd4;
            m_tvalid_reg <= 1'b0;
            slot_cnt_reg <= '0;
            n_reg        <= '0;
            for (int i = 0; i < MAX_INFLUENCES; i++)
            begin
                bone_reg[i] <= '0;
                wt_reg[i]   <= (i == 0) ? 17'(ONE_Q16) : 17'd0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            slot_cnt_reg <= slot_cnt_next;
            n_reg        <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (in_xfer && (s_tuser == CMD_SET_SLOT) && (int'(in_slot) < MAX_INFLUENCES))
            begin
                bone_reg[SW'(in_slot)] <= in_bone;
                wt_reg[SW'(in_slot)]   <= in_weight;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        c_reg       <= c_next;
        pos_reg     <= pos_next;
        row_reg     <= row_next;
        sq_reg      <= sq_next;
        len_reg     <= len_next;
        m_tdata_reg <= m_tdata_next;
        for (int i = 0; i < 3; i++)
        begin
            v_reg[i]   <= v_next[i];
            acc_reg[i] <= acc_next[i];
            val_reg[i] <= val_next[i];
        end
    end

    // checks
    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD_WORD || s_tuser == CMD_SET_SLOT)
        |=> s_tready)
        else $error("not ready after a load or slot transfer");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (slot_cnt_reg <= n_reg))
        else $error("slot counter beyond active count");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> (state_reg == ST_SQRT_W || state_reg == ST_DIV_W))
        else $error("unit finished outside a wait state");

endmodule

>>> hdl/lbs_mul.sv
`timescale 1ns / 1ps
// shared signed 33x33 multiplier with registered product
// depends on nothing but its ports
module lbs_mul
(
    input  logic                clk,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    output logic signed [65:0]  p
);

    logic signed [65:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> hdl/lbs_divsqrt.sv
`timescale 1ns / 1ps
// iterative shift-subtract unit: 64-bit integer square root or 48/32 division
// depends on lbs_pkg
module lbs_divsqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  lbs_pkg::ds_req_t   req,
    input  logic [63:0]        operand,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic [47:0]        result
);
    import lbs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mode_reg, mode_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] sh_reg, sh_next;
    logic [35:0] rem_reg, rem_next;
    logic [47:0] res_reg, res_next;
    logic [31:0] dv_reg, dv_next;
    logic [35:0] rem_sh, trial;
    logic        ge;

    // one result bit per cycle
    always_comb
    begin
        rem_sh = mode_reg ? {rem_reg[33:0], sh_reg[63:62]} : {rem_reg[34:0], sh_reg[63]};
        trial  = mode_reg ? {2'b00, res_reg[31:0], 2'b01} : {4'b0000, dv_reg};
        ge     = rem_sh >= trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        dv_next   = dv_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            mode_next = req.sqrt_mode;
            cnt_next  = req.sqrt_mode ? 6'd32 : 6'd48;
            sh_next   = operand;
            rem_next  = '0;
            res_next  = '0;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = mode_reg ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
            rem_next = ge ? rem_sh - trial : rem_sh;
            res_next = {res_reg[46:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        dv_reg   <= dv_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for linear_blend_skinning_vertex_core: random and directed
// matrix loads, slot sets and transforms checked against an in-bench predictor
// depends on lbs_pkg and the core rtl
module tb;
    import lbs_pkg::*;

    localparam int BONES     = 256;
    localparam int SLOTS     = 4;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 1500;
    localparam int IDLE_PCT  = 29;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  bone;
        logic [3:0]  word;
        logic [31:0] mval;
        logic [1:0]  slot;
        logic [16:0] wt;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } skin_item_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [159:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_data;

    // predictor state
    logic [31:0]   bone_words [0:BONES*WORDS_PER_BONE-1];
    logic [7:0]    slot_bone [0:SLOTS-1];
    logic [16:0]   slot_wt [0:SLOTS-1];
    int unsigned   active_cnt;

    // stimulus-side bookkeeping of which bones are fully loaded
    logic [11:0]   loaded_words [0:BONES-1];
    int            ready_bones [$];

    skin_item_t    send_q [$];
    skin_item_t    on_wire;
    logic [95:0]   blend_q [$];
    bit            calm;
    int            n_in, n_pos, n_dir, n_out, n_err;

    linear_blend_skinning_vertex_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // weighted blend over the active slots, normalized for a direction
    function automatic logic [95:0] blend_vertex(input skin_item_t it);
        longint          v [3];
        longint          acc [3];
        longint          rowv;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned q;
        int              n;
        int              base;
        logic [95:0]     res;
        v[0] = longint'($signed(it.vx));
        v[1] = longint'($signed(it.vy));
        v[2] = longint'($signed(it.vz));
        acc[0] = 0; acc[1] = 0; acc[2] = 0;
        n = (active_cnt > SLOTS) ? SLOTS : active_cnt;
        for (int s = 0; s < n; s++)
        begin
            base = slot_bone[s] * WORDS_PER_BONE;
            for (int r = 0; r < 3; r++)
            begin
                rowv = 0;
                for (int c = 0; c < 3; c++)
                    rowv += (longint'($signed(bone_words[base + r*4 + c])) * v[c]) >>> 16;
                if (it.cmd == CMD_XFORM_POS)
                    rowv += longint'($signed(bone_words[base + r*4 + 3]));
                rowv = clip32(rowv);
                acc[r] += (rowv * longint'({47'd0, slot_wt[s]})) >>> 16;
            end
        end
        for (int r = 0; r < 3; r++)
            acc[r] = clip32(acc[r]);
        if (it.cmd == CMD_XFORM_DIR)
        begin
            sq = 0;
            for (int r = 0; r < 3; r++)
            begin
                mag = (acc[r] < 0) ? -acc[r] : acc[r];
                sq += mag * mag;
            end
            len = int_sqrt(sq);
            for (int r = 0; r < 3; r++)
            begin
                if (len == 0)
                    acc[r] = 0;
                else
                begin
                    mag = (acc[r] < 0) ? -acc[r] : acc[r];
                    q = (mag << 16) / len;
                    acc[r] = (acc[r] < 0) ? -longint'(q) : longint'(q);
                end
            end
        end
        res = {acc[2][31:0], acc[1][31:0], acc[0][31:0]};
        return res;
    endfunction

    // update predictor state for one accepted item
    task automatic apply_item(input skin_item_t it);
        case (it.cmd)
            CMD_LOAD_WORD:
                if (it.word < WORDS_PER_BONE)
                    bone_words[it.bone * WORDS_PER_BONE + it.word] = it.mval;
            CMD_SET_SLOT:
                if (it.slot < SLOTS)
                begin
                    slot_bone[it.slot] = it.bone;
                    slot_wt[it.slot] = it.wt;
                end
            default:
            begin
                blend_q = {blend_q, blend_vertex(it)};
                if (it.cmd == CMD_XFORM_POS)
                    n_pos++;
                else
                    n_dir++;
            end
        endcase
    endtask

    // input driver: holds tvalid until the transfer completes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_item(on_wire);
                n_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_wire = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_wire.cmd;
                    s_tdata  <= {1'b0, on_wire.vz, on_wire.vy, on_wire.vx, on_wire.wt,
                                 on_wire.slot, on_wire.mval, on_wire.word, on_wire.bone};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor with random stalls and one long hold-off
    int  hold_left;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_out++;
                if (blend_q.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    n_err++;
                end
                else
                begin
                    logic [95:0] want;
                    want = blend_q.pop_front();
                    if (want[31:0] !== m_tdata[31:0])
                    begin
                        $error("out_x expected %0d got %0d", $signed(want[31:0]),
                               $signed(m_tdata[31:0]));
                        n_err++;
                    end
                    if (want[63:32] !== m_tdata[63:32])
                    begin
                        $error("out_y expected %0d got %0d", $signed(want[63:32]),
                               $signed(m_tdata[63:32]));
                        n_err++;
                    end
                    if (want[95:64] !== m_tdata[95:64])
                    begin
                        $error("out_z expected %0d got %0d", $signed(want[95:64]),
                               $signed(m_tdata[95:64]));
                        n_err++;
                    end
                end
            end
            if (!hold_done && n_out == 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_MAX)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] rand_q16();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(262143) - 131072;
    endfunction

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] bone,
                             input logic [3:0] word, input logic [31:0] mval,
                             input logic [1:0] slot, input logic [16:0] wt,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
        skin_item_t it;
        it.cmd = cmd; it.bone = bone; it.word = word; it.mval = mval;
        it.slot = slot; it.wt = wt; it.vx = vx; it.vy = vy; it.vz = vz;
        if (cmd == CMD_LOAD_WORD && word < WORDS_PER_BONE)
        begin
            if (loaded_words[bone] != 12'hfff && (loaded_words[bone] | (12'd1 << word)) == 12'hfff)
                ready_bones = {ready_bones, int'(bone)};
            loaded_words[bone][word] = 1'b1;
        end
        send_q = {send_q, it};
    endtask

    task automatic load_bone(input logic [7:0] bone);
        for (int w = 0; w < WORDS_PER_BONE; w++)
            push_item(CMD_LOAD_WORD, bone, 4'(w), rand_q16(), 2'($urandom), 17'($urandom),
                      $urandom, $urandom, $urandom);
    endtask

    // one phase of random traffic, mostly well formed
    task automatic random_phase(input int count);
        int k;
        logic [16:0] wt;
        k = 0;
        while (k < count)
        begin
            case ($urandom_range(19))
                0, 1:
                begin
                    load_bone(8'($urandom));
                    k += WORDS_PER_BONE;
                end
                2, 3, 4, 5, 6:
                begin
                    case ($urandom_range(4))
                        0: wt = 17'd0;
                        1: wt = 17'($urandom);
                        2: wt = 17'h1ffff;
                        default: wt = 17'($urandom_range(65536));
                    endcase
                    push_item(CMD_SET_SLOT,
                              8'(ready_bones[$urandom_range(ready_bones.size()-1)]),
                              4'($urandom), $urandom, 2'($urandom), wt,
                              $urandom, $urandom, $urandom);
                    k++;
                end
                7, 8:
                begin
                    // ignored load, or a stray word that overwrites one matrix word
                    if ($urandom_range(1))
                        push_item(CMD_LOAD_WORD, 8'($urandom), 4'($urandom_range(15, 12)),
                                  $urandom, 2'($urandom), 17'($urandom),
                                  $urandom, $urandom, $urandom);
                    else
                        push_item(CMD_LOAD_WORD, 8'($urandom), 4'($urandom_range(11)),
                                  $urandom, 2'($urandom), 17'($urandom),
                                  $urandom, $urandom, $urandom);
                    k++;
                end
                default:
                begin
                    push_item($urandom_range(1) ? CMD_XFORM_POS : CMD_XFORM_DIR, 8'($urandom),
                              4'($urandom), $urandom, 2'($urandom), 17'($urandom),
                              rand_q16(), rand_q16(), rand_q16());
                    k++;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (send_q.size() > 0 || s_tvalid || blend_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_active(input logic [2:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        active_cnt = {29'd0, v};
        cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    int settings [8] = '{1, 2, 3, 0, 7, 4, 5, 6};
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        n_in = 0; n_pos = 0; n_dir = 0; n_out = 0; n_err = 0;
        for (int b = 0; b < BONES; b++)
            loaded_words[b] = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_bone[s] = '0;
            slot_wt[s] = '0;
        end
        slot_wt[0] = ONE_Q16;
        active_cnt = 4;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_active(3'd4);

        // directed: extreme matrix words, ignored load, extreme weights, edge vectors
        for (int w = 0; w < WORDS_PER_BONE; w++)
            push_item(CMD_LOAD_WORD, 8'd0, 4'(w),
                      (w == 0) ? 32'h7fffffff : (w == 5) ? 32'h80000000 :
                      (w == 10) ? 32'h00010000 : rand_q16(), '0, '0, '0, '0, '0);
        push_item(CMD_LOAD_WORD, 8'd0, 4'd13, 32'hffffffff, '0, '0, '0, '0, '0);
        push_item(CMD_XFORM_POS, '0, '0, '0, '0, '0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_item(CMD_SET_SLOT, 8'd0, '0, '0, 2'd1, 17'h1ffff, '0, '0, '0);
        push_item(CMD_SET_SLOT, 8'd0, '0, '0, 2'd3, 17'd0, '0, '0, '0);
        push_item(CMD_XFORM_POS, '0, '0, '0, '0, '0, 32'h80000000, 32'h80000000, 32'h80000000);
        push_item(CMD_XFORM_DIR, '0, '0, '0, '0, '0, '0, '0, '0);
        push_item(CMD_XFORM_DIR, '0, '0, '0, '0, '0, 32'h00010000, 32'hffff0000, 32'h7fffffff);
        push_item(CMD_XFORM_POS, '0, '0, '0, '0, '0, '0, '0, '0);
        wait_drained();

        // random phases across register settings
        for (int p = 0; p < 8; p++)
        begin
            write_active(3'(settings[p]));
            calm = (p == 2);
            random_phase(90);
            wait_drained();
        end

        $display("tb: %0d items sent, %0d positions and %0d directions checked",
                 n_in, n_pos, n_dir);
        $display("tb: influence counts 0 to 7 used, %0d results received", n_out);
        if (n_err == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/lbs_pkg.sv
hdl/lbs_mul.sv
hdl/lbs_divsqrt.sv
hdl/linear_blend_skinning_vertex_core.sv
dv/tb.sv
